FILE: design/hcbp_pkg.sv
// Shared types and constants for the Huffman code bit packer.
package hcbp_pkg;

  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_SYMBOL_COUNT = 256;
  localparam int BYTE_BITS        = 8;
  localparam int MAX_BYTES        = 4;
  localparam int CODE_FIELD_W     = 32;
  localparam int LEN_FIELD_W      = 6;
  localparam int ACC_W            = CODE_FIELD_W + BYTE_BITS;

  typedef enum logic [1:0] {
    OP_ENCODE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [7:0]               symbol;
    logic [LEN_FIELD_W-1:0]   code_length;
    logic [CODE_FIELD_W-1:0]  code_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

endpackage

FILE: design/hcbp_if.sv
// Valid/ready channel interfaces for input items and output bytes.
interface hcbp_in_if import hcbp_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface hcbp_out_if import hcbp_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: design/huffman_code_bit_packer.sv
// Huffman code bit packer: code table in RAM, LSB-first byte packing and byte emitter.
//
// Users see a two-stage path. A beat on symbols is taken when ready is high; a
// load beat writes its table entry in that same cycle, an encode beat starts a
// table read. In the next cycle the pack stage joins the entry's code bits with
// the pending partial byte and hands every completed byte to the emitter, whose
// registers then drive the output port. The emitter sends one byte per cycle while
// ready is high, and the pack stage moves on as soon as the emitter is about to
// drain, so with ready high, items that make at most one byte run at one item
// per cycle; an item making k bytes holds the output port until all k are sent
// (at most four, for a 32-bit code on top of seven pending bits). Loads, flushes
// with nothing pending and zero-length codes never wait on the emitter. A flush
// zero-pads and emits the partial byte with last set; last also marks the final
// byte of each encode. The code table is not cleared by reset: encoding a symbol
// that was never loaded is not allowed.
module huffman_code_bit_packer import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  logic         clk,
  input  logic         rst,
  hcbp_in_if.sink      symbols,
  hcbp_out_if.source   packed_bytes
);

  // Stored code length is capped at the smaller of the parameter and 32.
  localparam int CapLen = (MAX_CODE_LEN > CODE_FIELD_W) ? CODE_FIELD_W : MAX_CODE_LEN;
  localparam int LenW   = $clog2(CapLen + 1);
  localparam int AddrW  = $clog2(SYMBOL_COUNT);
  localparam int EntryW = LenW + CapLen;

  // ---------------------------------------------------------------------------
  // Input stage: table write on load, table read on encode
  // ---------------------------------------------------------------------------
  logic              in_fire;
  logic              sym_ok;
  logic [LenW-1:0]   len_sat;
  logic [EntryW-1:0] wr_data;
  logic [EntryW-1:0] rd_data;

  assign in_fire = symbols.valid && symbols.ready;
  assign sym_ok  = 32'(symbols.data.symbol) < SYMBOL_COUNT;
  assign len_sat = (32'(symbols.data.code_length) > CapLen) ? LenW'(CapLen)
                                                            : LenW'(symbols.data.code_length);
  assign wr_data = {len_sat, symbols.data.code_value[CapLen-1:0]};

  // A load writes at its own accept edge, so an encode of the same symbol in the
  // next cycle already reads the new entry; no forwarding path is needed.
  hcbp_ram #(
    .Width (EntryW),
    .Depth (SYMBOL_COUNT)
  ) u_table (
    .clk     (clk),
    .wr_en   (in_fire && symbols.data.op == OP_LOAD && sym_ok),
    .wr_addr (symbols.data.symbol[AddrW-1:0]),
    .wr_data (wr_data),
    .rd_en   (in_fire && symbols.data.op == OP_ENCODE),
    .rd_addr (symbols.data.symbol[AddrW-1:0]),
    .rd_data (rd_data)
  );

  // Pack stage registers
  logic s1_valid;
  op_t  s1_op;
  logic s1_sym_ok;

  // Pending partial byte
  logic [7:0] pend_bits;
  logic [2:0] pend_count;

  // Byte emitter
  logic [CODE_FIELD_W-1:0] eword;
  logic [2:0]              ecount;

  // ---------------------------------------------------------------------------
  // Pack stage
  // ---------------------------------------------------------------------------
  logic [LenW-1:0]   rd_len;
  logic [CapLen-1:0] rd_code;
  logic [CapLen-1:0] code_m;
  logic [ACC_W-1:0]  acc;
  logic [5:0]        total;
  logic [ACC_W-1:0]  acc_rest;
  logic [7:0]        rest_mask;

  assign rd_len  = rd_data[EntryW-1 -: LenW];
  assign rd_code = rd_data[CapLen-1:0];

  always_comb begin
    for (int i = 0; i < CapLen; i++) begin
      code_m[i] = rd_code[i] && (32'(i) < 32'(rd_len));
    end
  end

  assign acc       = {{CODE_FIELD_W{1'b0}}, pend_bits} | (ACC_W'(code_m) << pend_count);
  assign total     = 6'(pend_count) + 6'(rd_len);
  assign acc_rest  = acc >> {total[5:3], 3'b000};
  assign rest_mask = 8'((16'd1 << total[2:0]) - 16'd1);

  // What this item leaves behind: bytes for the emitter and the new partial byte.
  logic [2:0]              s1_nbytes;
  logic [CODE_FIELD_W-1:0] s1_word;
  logic                    s1_upd;
  logic [7:0]              pend_bits_next;
  logic [2:0]              pend_count_next;

  always_comb begin
    s1_nbytes       = 3'd0;
    s1_word         = acc[CODE_FIELD_W-1:0];
    s1_upd          = 1'b0;
    pend_bits_next  = pend_bits;
    pend_count_next = pend_count;
    case (s1_op)
      OP_ENCODE: begin
        if (s1_sym_ok) begin
          s1_nbytes       = total[5:3];
          s1_upd          = 1'b1;
          pend_bits_next  = acc_rest[7:0] & rest_mask;
          pend_count_next = total[2:0];
        end
      end
      OP_FLUSH: begin
        s1_nbytes       = (pend_count != 3'd0) ? 3'd1 : 3'd0;
        s1_word         = CODE_FIELD_W'(pend_bits);
        s1_upd          = 1'b1;
        pend_bits_next  = 8'd0;
        pend_count_next = 3'd0;
      end
      default: ;
    endcase
  end

  // The pack stage retires when it makes no bytes, or when the emitter is empty
  // or sends its final byte this cycle.
  logic out_fire;
  logic emit_free;
  logic s1_done;
  logic eload;

  assign out_fire  = packed_bytes.valid && packed_bytes.ready;
  assign emit_free = (ecount == 3'd0) || (ecount == 3'd1 && packed_bytes.ready);
  assign s1_done   = s1_valid && (s1_nbytes == 3'd0 || emit_free);
  assign eload     = s1_done && s1_nbytes != 3'd0;

  assign symbols.ready = !s1_valid || s1_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      pend_bits  <= 8'd0;
      pend_count <= 3'd0;
    end else begin
      if (symbols.ready) begin
        s1_valid <= symbols.valid;
      end
      if (s1_done && s1_upd) begin
        pend_bits  <= pend_bits_next;
        pend_count <= pend_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op     <= symbols.data.op;
      s1_sym_ok <= sym_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte emitter: low byte goes out, then shift down
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ecount <= 3'd0;
    end else if (eload) begin
      ecount <= s1_nbytes;
    end else if (out_fire) begin
      ecount <= ecount - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (eload) begin
      eword <= s1_word;
    end else if (out_fire) begin
      eword <= eword >> BYTE_BITS;
    end
  end

  assign packed_bytes.valid         = ecount != 3'd0;
  assign packed_bytes.data.out_byte = eword[7:0];
  assign packed_bytes.data.last     = ecount == 3'd1;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ecount_range: assert property (@(posedge clk) disable iff (rst)
    32'(ecount) <= MAX_BYTES)
    else $error("emitter holds more bytes than one item can make");

  a_load_only_when_drained: assert property (@(posedge clk) disable iff (rst)
    eload |-> (ecount == 3'd0 || (ecount == 3'd1 && out_fire)))
    else $error("emitter overwritten while bytes remain");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_done) |=> (s1_valid && $stable(s1_op) && $stable(pend_count)))
    else $error("pack stage changed while stalled");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_done && s1_op == OP_FLUSH) |=> (pend_count == 3'd0 && pend_bits == 8'd0))
    else $error("flush left pending bits");

endmodule

FILE: design/hcbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hcbp_ram import hcbp_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: test/hcbp_byte_checker.sv
// Checker for the code bit packer: predicts output bytes from input beats and compares them.
module hcbp_byte_checker import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  logic clk,
  input  logic rst,
  hcbp_in_if   symbols,
  hcbp_out_if  packed_bytes,
  output int   errors,
  output int   bytes_owed
);

  logic [LEN_FIELD_W-1:0]  len_tab  [SYMBOL_COUNT];
  logic [CODE_FIELD_W-1:0] code_tab [SYMBOL_COUNT];
  logic [7:0]              part_bits;
  int unsigned             part_cnt;
  out_item_t               expected_bytes[$];

  initial begin
    errors     = 0;
    bytes_owed = 0;
    part_bits  = '0;
    part_cnt   = 0;
    for (int i = 0; i < SYMBOL_COUNT; i++) begin
      len_tab[i]  = '0;
      code_tab[i] = '0;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    errors++;
  endtask

  // Stored length saturates at the smaller of MAX_CODE_LEN and the code field width.
  function automatic int unsigned clamp_len(input logic [LEN_FIELD_W-1:0] req);
    int unsigned cap;
    cap = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
    return (req > cap) ? cap : int'(req);
  endfunction

  // Applies one input beat to the table and bit buffer, queueing the bytes it yields.
  task automatic pack_code(input in_item_t it);
    logic [63:0] code;
    logic [63:0] acc;
    int unsigned len;
    int unsigned total;
    int unsigned n;
    out_item_t   ob;
    case (it.op)
      OP_LOAD: begin
        if (it.symbol < SYMBOL_COUNT) begin
          len_tab[it.symbol]  = LEN_FIELD_W'(clamp_len(it.code_length));
          code_tab[it.symbol] = it.code_value;
        end
      end
      OP_FLUSH: begin
        if (part_cnt != 0) begin
          ob.out_byte = part_bits;
          ob.last     = 1'b1;
          expected_bytes.push_back(ob);
        end
        part_bits = '0;
        part_cnt  = 0;
      end
      OP_ENCODE: begin
        if (it.symbol < SYMBOL_COUNT && len_tab[it.symbol] != 0) begin
          len  = len_tab[it.symbol];
          code = 64'(code_tab[it.symbol]);
          if (len < 32) code &= (64'd1 << len) - 64'd1;
          acc   = 64'(part_bits) | (code << part_cnt);
          total = part_cnt + len;
          n     = 0;
          while (total >= BYTE_BITS && n < MAX_BYTES) begin
            ob.out_byte = acc[7:0];
            // final byte of the item: fewer than two bytes' worth left, or the cap
            ob.last     = (total < 2 * BYTE_BITS) || (n == MAX_BYTES - 1);
            expected_bytes.push_back(ob);
            n++;
            acc   = acc >> BYTE_BITS;
            total = total - BYTE_BITS;
          end
          part_cnt  = total % BYTE_BITS;
          part_bits = (part_cnt != 0) ? (acc[7:0] & ((8'd1 << part_cnt) - 8'd1)) : 8'd0;
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst) begin
      part_bits = '0;
      part_cnt  = 0;
      expected_bytes.delete();
    end else begin
      // output side first: a byte can never stem from the input beat of this same edge
      if (packed_bytes.valid && packed_bytes.ready) begin
        got = packed_bytes.data;
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h last %0b with nothing expected",
                                    got.out_byte, got.last));
        end else begin
          want = expected_bytes.pop_front();
          if (got.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      got.out_byte, want.out_byte));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %0b on byte %02h, expected %0b",
                                      got.last, got.out_byte, want.last));
        end
      end
      if (symbols.valid && symbols.ready) pack_code(symbols.data);
    end
    bytes_owed <= expected_bytes.size();
  end

endmodule

FILE: test/huffman_code_bit_packer_tb.sv
// Testbench top for the code bit packer: stimulus, output back-pressure, watchdog and verdict.
module huffman_code_bit_packer_tb;
  import hcbp_pkg::*;

  localparam int RAND_ITEMS  = 435;   // random beats that reach the packer (noise not counted)
  localparam int HOLD_CYCLES = 300;   // long output hold-off to fill the pipe
  localparam int IDLE_LIMIT  = 2000;  // cycles with no beat on either side before giving up
  localparam int TAIL_CYCLES = 20;    // settle time after the last expected byte

  logic clk = 1'b0;
  logic rst;

  always #2 clk = ~clk;

  hcbp_in_if  sym_if();
  hcbp_out_if byte_if();

  int errors;
  int bytes_owed;
  int hold_reqs = 0;

  huffman_code_bit_packer i_dut (
    .clk          (clk),
    .rst          (rst),
    .symbols      (sym_if),
    .packed_bytes (byte_if)
  );

  hcbp_byte_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .symbols      (sym_if),
    .packed_bytes (byte_if),
    .errors       (errors),
    .bytes_owed   (bytes_owed)
  );

  // ---------------------------------------------------------------------------
  // Stimulus bookkeeping. The code table powers up undefined, so encodes only
  // ever pick symbols that have been loaded at least once.
  // ---------------------------------------------------------------------------
  bit          loaded [256];
  logic [7:0]  loaded_syms[$];
  int unsigned calm_left = 0;

  // Sender gap: mostly none or short, now and then long; sometimes a calm
  // stretch of back-to-back beats.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm_left = $urandom_range(20, 40);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one beat and hold it until accepted; valid only drops if a gap follows.
  task automatic send_item(input in_item_t it);
    int unsigned gap;
    sym_if.valid <= 1'b1;
    sym_if.data  <= it;
    do @(posedge clk); while (!sym_if.ready);
    gap = pick_gap();
    if (gap != 0) begin
      sym_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_entry(input logic [7:0] sym, input logic [LEN_FIELD_W-1:0] len,
                            input logic [CODE_FIELD_W-1:0] val);
    in_item_t it;
    it.op          = OP_LOAD;
    it.symbol      = sym;
    it.code_length = len;
    it.code_value  = val;
    if (!loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
    send_item(it);
  endtask

  // Length and value fields are don't-care on encode and flush; keep them noisy.
  task automatic encode_sym(input logic [7:0] sym);
    in_item_t it;
    it.op          = OP_ENCODE;
    it.symbol      = sym;
    it.code_length = LEN_FIELD_W'($urandom_range(0, 63));
    it.code_value  = $urandom();
    send_item(it);
  endtask

  task automatic flush_bits();
    in_item_t it;
    it.op          = OP_FLUSH;
    it.symbol      = 8'($urandom_range(0, 255));
    it.code_length = LEN_FIELD_W'($urandom_range(0, 63));
    it.code_value  = $urandom();
    send_item(it);
  endtask

  task automatic send_noise(input logic [7:0] sym, input logic [LEN_FIELD_W-1:0] len,
                            input logic [CODE_FIELD_W-1:0] val);
    in_item_t it;
    it.op          = OP_NONE;
    it.symbol      = sym;
    it.code_length = len;
    it.code_value  = val;
    send_item(it);
  endtask

  // Park the sender until every predicted byte has come out.
  task automatic wait_drained();
    sym_if.valid <= 1'b0;
    do @(posedge clk); while (bytes_owed != 0);
  endtask

  // Mostly short codes, some long ones, and a few lengths of zero or past the cap.
  function automatic logic [LEN_FIELD_W-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return LEN_FIELD_W'($urandom_range(1, 8));
    if (r < 85) return LEN_FIELD_W'($urandom_range(9, 20));
    if (r < 95) return LEN_FIELD_W'($urandom_range(21, 32));
    return LEN_FIELD_W'($urandom_range(0, 63));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  initial begin
    int counted;
    int unsigned r;
    bit held;
    bit parked;
    counted = 0;
    held    = 1'b0;
    parked  = 1'b0;
    rst          <= 1'b1;
    sym_if.valid <= 1'b0;
    sym_if.data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: table entries at the field extremes
    load_entry(8'd0,   6'd1,  32'h0000_0001);   // single-bit code
    load_entry(8'd255, 6'd32, 32'hFFFF_FFFF);   // full-width code, all ones
    load_entry(8'd1,   6'd63, 32'hA5A5_5A5A);   // overlong length, saturates
    load_entry(8'd2,   6'd0,  32'hFFFF_FFFF);   // zero-length code
    load_entry(8'd3,   6'd3,  32'hDEAD_BEE5);   // bits above the length ignored
    load_entry(8'd4,   6'd33, 32'h0000_0000);   // just past the cap, all-zero code
    load_entry(8'd5,   6'd8,  32'h0000_003C);   // exactly one byte
    flush_bits();                               // flush with nothing pending
    repeat (7) encode_sym(8'd0);                // seven bits pending, no byte yet
    encode_sym(8'd255);                         // 7 + 32 bits: worst case, four bytes
    encode_sym(8'd2);                           // zero length: nothing out
    send_noise(8'hFF, 6'h3F, 32'hFFFF_FFFF);    // unknown op, all fields high
    encode_sym(8'd1);
    encode_sym(8'd3);
    encode_sym(8'd4);
    encode_sym(8'd5);
    flush_bits();                               // pads the partial byte
    flush_bits();                               // back to empty
    wait_drained();

    // Random: mostly encodes of loaded symbols, with loads, flushes and noise mixed in
    while (counted < RAND_ITEMS) begin
      if (counted == 150 && !held) begin
        // receiver goes quiet for a long stretch while the sender keeps offering
        held = 1'b1;
        hold_reqs <= hold_reqs + 1;
      end
      if (counted == 300 && !parked) begin
        parked = 1'b1;
        wait_drained();
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_noise(8'($urandom_range(0, 255)), LEN_FIELD_W'($urandom_range(0, 63)),
                   $urandom());
      end else begin
        if (r < 13)
          load_entry(8'($urandom_range(0, 255)), pick_len(), $urandom());
        else if (r < 21)
          flush_bits();
        else
          encode_sym(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
        counted++;
      end
    end

    // Close out a trailing partial byte, then drain and let the pipe settle.
    flush_bits();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready with short stalls, rare long ones, long bursts of
  // ready, and the one long hold-off requested by the sender.
  // ---------------------------------------------------------------------------
  initial begin
    int run_left;
    int stall_left;
    int hold_left;
    int hold_seen;
    run_left   = 0;
    stall_left = 0;
    hold_left  = 0;
    hold_seen  = 0;
    byte_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (rst) begin
        byte_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        byte_if.ready <= 1'b0;
      end else if (run_left != 0) begin
        run_left--;
        byte_if.ready <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        byte_if.ready <= 1'b0;
      end else begin
        // new run/stall pair; the current cycle opens the run
        run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                 : $urandom_range(0, 6);
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 3);
        byte_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a run with no beat on either channel for too long is a hang.
  // ---------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (sym_if.valid && sym_if.ready) || (byte_if.valid && byte_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
